### sv/ffha_pkg.sv
// shared constants, payload structs and codes for the first-fit heap allocator
// no dependencies

package ffha_pkg;

  localparam int HEAP_MAX_BYTES  = 16384;
  localparam int HEADER_BYTES    = 12;
  localparam int MIN_SPLIT_BYTES = 16;

  localparam int STORE_DEPTH = HEAP_MAX_BYTES / 4;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int OFF_W       = $clog2(HEAP_MAX_BYTES);
  localparam int LEN_W       = OFF_W + 1;
  localparam int SUM_W       = LEN_W + 2;
  localparam int SIZE_W      = 15;
  localparam int ENTRY_W     = SIZE_W + 1;
  localparam int FREE_BIT    = SIZE_W;
  localparam int PADDR_W     = 3;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OOM  = 2'd2,
    ST_NULL = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [14:0] req_size;
    logic [31:0] free_addr;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] alloc_addr;
    logic [14:0] used_bytes;
    logic [14:0] free_bytes;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      base;
    logic [LEN_W-1:0] len;
    logic             init;
  } cfg_t;

endpackage

### sv/ffha_store.sv
// header memory: one entry per 4-byte block start, one write and one registered read
// depends on ffha_pkg

module ffha_store import ffha_pkg::*; (
  input  logic               clk,
  input  logic [SLOT_W-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data,
  input  logic               we,
  input  logic [SLOT_W-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data
);

  logic [ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/ffha_cfg.sv
// apb register file: heap base and heap size, effective region length, rebuild request
// depends on ffha_pkg

module ffha_cfg import ffha_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [31:0]      heap_base_r;
  logic [14:0]      heap_bytes_r;
  logic             init_r;
  logic             wr_en;
  logic             reg_idx;
  logic [14:0]      len_raw;
  logic [LEN_W-1:0] len;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_bytes_r <= 15'(HEAP_MAX_BYTES);
      init_r       <= 1'b1;
    end else begin
      init_r <= 1'b0;
      if (wr_en) begin
        unique case (reg_idx)
          REG_HEAP_BASE: begin
            heap_base_r <= pwdata;
          end
          REG_HEAP_BYTES: begin
            heap_bytes_r <= pwdata[14:0];
            init_r       <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAP_BASE:  prdata = heap_base_r;
      REG_HEAP_BYTES: prdata = {17'b0, heap_bytes_r};
      default:        prdata = '0;
    endcase
  end

  // clamp to the supported region length
  always_comb begin
    len_raw = {heap_bytes_r[14:2], 2'b00};
    priority if (len_raw < 15'd32) begin
      len = LEN_W'(32);
    end else if (32'(len_raw) > 32'(HEAP_MAX_BYTES)) begin
      len = LEN_W'(HEAP_MAX_BYTES);
    end else begin
      len = LEN_W'(len_raw);
    end
  end

  assign cfg.base = heap_base_r;
  assign cfg.len  = len;
  assign cfg.init = init_r;

endmodule

### sv/ffha_ctrl.sv
// header walk sequencer: first-fit search, split, free and neighbor merge, result register
// depends on ffha_pkg; drives the ports of ffha_store

module ffha_ctrl import ffha_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  output logic [SLOT_W-1:0]  rd_addr,
  input  logic [ENTRY_W-1:0] rd_data,
  output logic               we,
  output logic [SLOT_W-1:0]  wr_addr,
  output logic [ENTRY_W-1:0] wr_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_SPLIT = 6'b000100,
    S_NEXT  = 6'b001000,
    S_RESP  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [SUM_W-1:0]  want_r, want_nxt;
  logic [31:0]       target_r, target_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [OFF_W-1:0]  prev_off_r, prev_off_nxt;
  logic              prev_free_r, prev_free_nxt;
  logic [SIZE_W-1:0] prev_size_r, prev_size_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              has_next_r, has_next_nxt;
  logic [LEN_W-1:0]  used_r, used_nxt;
  status_t           status_r, status_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              h_free;
  logic [SIZE_W-1:0] h_size;
  logic [SUM_W-1:0]  nx;
  logic              at_end;
  logic              fits;
  logic              split;
  logic              hit;
  logic [SUM_W-1:0]  rest;
  logic [SUM_W-1:0]  rest_size;
  logic              next_free;
  logic [SUM_W-1:0]  merged;
  logic              accept;
  logic              out_load;

  assign h_free    = rd_data[FREE_BIT];
  assign h_size    = rd_data[SIZE_W-1:0];
  assign nx        = SUM_W'(off_r) + SUM_W'(HEADER_BYTES) + SUM_W'(h_size);
  assign at_end    = nx >= SUM_W'(cfg.len);
  assign fits      = h_free && (SUM_W'(h_size) >= want_r);
  assign split     = SUM_W'(h_size) >= want_r + SUM_W'(HEADER_BYTES + MIN_SPLIT_BYTES);
  assign hit       = target_r == 32'(off_r);
  assign rest      = SUM_W'(off_r) + SUM_W'(HEADER_BYTES) + want_r;
  assign rest_size = SUM_W'(size_r) - want_r - SUM_W'(HEADER_BYTES);
  assign next_free = has_next_r && h_free;
  assign merged    = (prev_free_r ? SUM_W'(prev_size_r) + SUM_W'(HEADER_BYTES) : '0)
                   + SUM_W'(size_r)
                   + (next_free ? SUM_W'(HEADER_BYTES) + SUM_W'(h_size) : '0);

  assign in_ready = (state_r == S_IDLE) && !cfg.init;
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    want_nxt      = want_r;
    target_nxt    = target_r;
    off_nxt       = off_r;
    prev_off_nxt  = prev_off_r;
    prev_free_nxt = prev_free_r;
    prev_size_nxt = prev_size_r;
    size_nxt      = size_r;
    has_next_nxt  = has_next_r;
    used_nxt      = used_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    rd_addr       = '0;
    we            = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_data.cmd;
          want_nxt      = (SUM_W'(in_data.req_size) + SUM_W'(3)) & ~SUM_W'(3);
          target_nxt    = in_data.free_addr - cfg.base - 32'(HEADER_BYTES);
          off_nxt       = '0;
          prev_free_nxt = 1'b0;
          addr_nxt      = '0;
          status_nxt    = ST_OK;
          priority if (in_data.cmd == CMD_ALLOC && in_data.req_size == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_RESP;
          end else if (in_data.cmd == CMD_FREE && in_data.free_addr == '0) begin
            status_nxt = ST_NULL;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        rd_addr = nx[OFF_W-1:2];
        unique case (cmd_r)
          CMD_ALLOC: begin
            priority if (fits) begin
              we       = 1'b1;
              wr_addr  = off_r[OFF_W-1:2];
              wr_data  = {1'b0, split ? want_r[SIZE_W-1:0] : h_size};
              size_nxt = h_size;
              used_nxt = used_r + LEN_W'(HEADER_BYTES)
                       + (split ? want_r[LEN_W-1:0] : LEN_W'(h_size));
              addr_nxt = cfg.base + 32'(off_r) + 32'(HEADER_BYTES);
              state_nxt = split ? S_SPLIT : S_RESP;
            end else if (at_end) begin
              status_nxt = ST_OOM;
              state_nxt  = S_RESP;
            end else begin
              off_nxt = nx[OFF_W-1:0];
            end
          end
          CMD_FREE: begin
            priority if (hit && h_free) begin
              state_nxt = S_RESP;
            end else if (hit) begin
              used_nxt     = used_r - LEN_W'(HEADER_BYTES) - LEN_W'(h_size);
              size_nxt     = h_size;
              has_next_nxt = !at_end;
              state_nxt    = S_NEXT;
            end else if (at_end) begin
              state_nxt = S_RESP;
            end else begin
              prev_off_nxt  = off_r;
              prev_free_nxt = h_free;
              prev_size_nxt = h_size;
              off_nxt       = nx[OFF_W-1:0];
            end
          end
          default: begin
          end
        endcase
      end

      S_SPLIT: begin
        we        = 1'b1;
        wr_addr   = rest[OFF_W-1:2];
        wr_data   = {1'b1, rest_size[SIZE_W-1:0]};
        state_nxt = S_RESP;
      end

      // merge the freed block with free neighbors on either side
      S_NEXT: begin
        we        = 1'b1;
        wr_addr   = prev_free_r ? prev_off_r[OFF_W-1:2] : off_r[OFF_W-1:2];
        wr_data   = {1'b1, merged[SIZE_W-1:0]};
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // region rebuild after reset or a heap size write
    if (cfg.init) begin
      we       = 1'b1;
      wr_addr  = '0;
      wr_data  = {1'b1, SIZE_W'(cfg.len - LEN_W'(HEADER_BYTES))};
      used_nxt = '0;
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_data_nxt.status     = status_r;
      out_data_nxt.alloc_addr = addr_r;
      out_data_nxt.used_bytes = 15'(used_r);
      out_data_nxt.free_bytes = 15'(cfg.len - used_r);
      out_valid_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    want_r      <= want_nxt;
    target_r    <= target_nxt;
    off_r       <= off_nxt;
    prev_off_r  <= prev_off_nxt;
    prev_free_r <= prev_free_nxt;
    prev_size_r <= prev_size_nxt;
    size_r      <= size_nxt;
    has_next_r  <= has_next_nxt;
    status_r    <= status_nxt;
    addr_r      <= addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/first_fit_heap_allocator.sv
// first-fit heap allocator top level: apb registers, header memory and walk sequencer
// depends on ffha_pkg, ffha_cfg, ffha_store, ffha_ctrl

// The heap is kept as a chain of block headers in an on-chip header memory with
// a registered read. An allocate or free walks that chain from the region start,
// one header per cycle; an allocate that splits writes the remainder header in
// S_SPLIT, and every free that releases an allocated block writes the merged
// header in S_NEXT. A result that waits in the output register does not block the
// next transfer being taken. Zero-size allocates and null frees skip the walk and
// go straight to S_RESP. After reset, and after any write to heap_bytes, the region
// is rebuilt as a single free block before the next transfer is taken; heap_base
// writes only move the reported addresses.

module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  cfg_t               cfg;
  logic [SLOT_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               we;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  ffha_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffha_store u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

### verif/testbench.sv
// self-checking bench for first_fit_heap_allocator: random and directed alloc/free traffic
// predicts every reply with its own block-chain heap image; needs ffha_pkg and the rtl top
`timescale 1ns / 100ps

module testbench;
  import ffha_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t    heap_ops[$];
  out_item_t   heap_replies[$];
  logic [31:0] live_blocks[$];
  logic [31:0] released_addrs[$];

  int unsigned ops_sent = 0;
  int unsigned ops_taken = 0;
  int unsigned errors = 0;
  int unsigned idle_run = 0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  // heap image: one header per 4-byte offset
  logic [ENTRY_W-1:0] heap_hdr[STORE_DEPTH];
  logic [31:0]        cur_base;
  logic [14:0]        cur_bytes;
  int unsigned        used_sum;
  int unsigned        free_sum;

  first_fit_heap_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned span_len();
    int unsigned n;
    n = {17'd0, cur_bytes} & 32'hFFFF_FFFC;
    if (n < 32) n = 32;
    if (n > HEAP_MAX_BYTES) n = HEAP_MAX_BYTES & 32'hFFFF_FFFC;
    return n;
  endfunction

  function automatic int unsigned hdr_idx(int unsigned off);
    return (off >> 2) % STORE_DEPTH;
  endfunction

  function automatic int unsigned next_off(int unsigned off);
    return off + HEADER_BYTES + heap_hdr[hdr_idx(off)][SIZE_W-1:0];
  endfunction

  function automatic void rebuild_heap();
    int unsigned len;
    len = span_len();
    for (int i = 0; i < STORE_DEPTH; i++) heap_hdr[i] = '0;
    heap_hdr[0] = {1'b1, SIZE_W'(len - HEADER_BYTES)};
    used_sum = 0;
    free_sum = len;
  endfunction

  function automatic void recount_totals();
    int unsigned len, off, b;
    len = span_len();
    off = 0;
    used_sum = 0;
    free_sum = 0;
    for (int n = 0; off < len && n < STORE_DEPTH; n++) begin
      b = HEADER_BYTES + heap_hdr[hdr_idx(off)][SIZE_W-1:0];
      if (heap_hdr[hdr_idx(off)][FREE_BIT]) free_sum += b;
      else used_sum += b;
      off += b;
    end
  endfunction

  function automatic void merge_free_runs();
    int unsigned len, off, nx, sz;
    logic [ENTRY_W-1:0] h;
    len = span_len();
    off = 0;
    for (int n = 0; off < len && n < 2 * STORE_DEPTH; n++) begin
      nx = next_off(off);
      h = heap_hdr[hdr_idx(off)];
      if (nx < len && h[FREE_BIT] && heap_hdr[hdr_idx(nx)][FREE_BIT]) begin
        sz = h[SIZE_W-1:0] + HEADER_BYTES + heap_hdr[hdr_idx(nx)][SIZE_W-1:0];
        heap_hdr[hdr_idx(off)] = {1'b1, sz[SIZE_W-1:0]};
      end else begin
        off = nx;
      end
    end
  endfunction

  function automatic out_item_t heap_predict(in_item_t op);
    out_item_t r;
    int unsigned len, off, want, bsize, rest_off;
    logic [31:0] target;
    bit found;
    r = '0;
    r.status = ST_OK;
    len = span_len();
    off = 0;
    found = 1'b0;
    if (op.cmd == CMD_ALLOC) begin
      if (op.req_size == 0) begin
        r.status = ST_ZERO;
      end else begin
        want = ({17'd0, op.req_size} + 3) & 32'hFFFF_FFFC;
        for (int n = 0; off < len && n < STORE_DEPTH; n++) begin
          if (heap_hdr[hdr_idx(off)][FREE_BIT] && heap_hdr[hdr_idx(off)][SIZE_W-1:0] >= want) begin
            found = 1'b1;
            break;
          end
          off = next_off(off);
        end
        if (!found) begin
          r.status = ST_OOM;
        end else begin
          bsize = heap_hdr[hdr_idx(off)][SIZE_W-1:0];
          if (bsize >= want + HEADER_BYTES + MIN_SPLIT_BYTES) begin
            rest_off = off + HEADER_BYTES + want;
            heap_hdr[hdr_idx(rest_off)] = {1'b1, SIZE_W'(bsize - want - HEADER_BYTES)};
            heap_hdr[hdr_idx(off)] = {1'b0, SIZE_W'(want)};
          end else begin
            heap_hdr[hdr_idx(off)] = {1'b0, SIZE_W'(bsize)};
          end
          r.alloc_addr = cur_base + off + HEADER_BYTES;
        end
      end
    end else if (op.free_addr == 0) begin
      r.status = ST_NULL;
    end else begin
      target = op.free_addr - cur_base - HEADER_BYTES;
      for (int n = 0; off < len && n < STORE_DEPTH; n++) begin
        if (off == target) begin
          heap_hdr[hdr_idx(off)][FREE_BIT] = 1'b1;
          break;
        end
        off = next_off(off);
      end
      merge_free_runs();
    end
    recount_totals();
    r.used_bytes = used_sum[14:0];
    r.free_bytes = free_sum[14:0];
    return r;
  endfunction

  function automatic string fmt_reply(out_item_t r);
    return $sformatf("status=%0d addr=%h used=%0d free=%0d",
                     r.status, r.alloc_addr, r.used_bytes, r.free_bytes);
  endfunction

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (heap_ops.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= heap_ops.pop_front();
        tx_gap <= tx_idle ? $urandom_range(0, 19) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    int unsigned rx_draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_draw = rx_idle ? $urandom_range(0, 19) : 0;
      rx_wait <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor, predictor hookup and watchdog
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (heap_replies.size() == 0) begin
          log_error($sformatf("unexpected result %s", fmt_reply(out_data)));
        end else begin
          exp_r = heap_replies.pop_front();
          if (out_data.status !== exp_r.status || out_data.alloc_addr !== exp_r.alloc_addr ||
              out_data.used_bytes !== exp_r.used_bytes ||
              out_data.free_bytes !== exp_r.free_bytes)
            log_error($sformatf("expected %s, got %s", fmt_reply(exp_r), fmt_reply(out_data)));
        end
      end
      if (in_valid && in_ready) begin
        exp_r = heap_predict(in_data);
        heap_replies.push_back(exp_r);
        ops_taken++;
        if (in_data.cmd == CMD_ALLOC && exp_r.status == ST_OK)
          live_blocks.push_back(exp_r.alloc_addr);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (ops_taken == ops_sent && heap_replies.size() == 0)) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run >= STALL_LIMIT) begin
          $display("FAIL first_fit_heap_allocator");
          $finish;
        end
      end
    end
  end

  task automatic push_op(input cmd_t c, input logic [14:0] size, input logic [31:0] addr);
    in_item_t it;
    it.cmd = c;
    it.req_size = size;
    it.free_addr = addr;
    heap_ops.push_back(it);
    ops_sent++;
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drain();
    while (ops_taken != ops_sent || heap_replies.size() != 0) @(negedge clk);
  endtask

  task automatic queue_random_op(output bit counted);
    int unsigned pick, idx;
    logic [14:0] size;
    logic [31:0] addr;
    pick = $urandom_range(0, 99);
    size = 15'($urandom);
    addr = $urandom;
    counted = 1'b1;
    if (pick < 5) begin
      push_op(CMD_ALLOC, 15'd0, addr);
    end else if (pick < 8) begin
      push_op(CMD_FREE, size, 32'd0);
      counted = 1'b0;
    end else if (pick < 12) begin
      if (live_blocks.size() != 0 && pick[0])
        addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)] + 32'($urandom_range(1, 8));
      push_op(CMD_FREE, size, addr);
    end else if (pick < 15 && released_addrs.size() != 0) begin
      push_op(CMD_FREE, size, released_addrs[$urandom_range(0, released_addrs.size() - 1)]);
    end else if (pick < 50 && live_blocks.size() != 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      addr = live_blocks[idx];
      live_blocks.delete(idx);
      released_addrs.push_back(addr);
      if (released_addrs.size() > 16) void'(released_addrs.pop_front());
      push_op(CMD_FREE, size, addr);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) size = 15'($urandom_range(1, 48));
      else if (pick < 95) size = 15'($urandom_range(49, 400));
      else size = 15'($urandom_range(1, 32767));
      push_op(CMD_ALLOC, size, addr);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned done_n;
    bit counted;
    done_n = 0;
    while (done_n < count) begin
      @(negedge clk);
      if (heap_ops.size() < 3) begin
        queue_random_op(counted);
        if (counted) done_n++;
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [14:0] bytes, input bit new_heap,
                           input bit tx, input bit rx, input bit hold, input int unsigned count);
    wait_drain();
    cfg_write({REG_HEAP_BASE, 2'b00}, base);
    cur_base = base;
    if (new_heap) begin
      cfg_write({REG_HEAP_BYTES, 2'b00}, {17'd0, bytes});
      cur_bytes = bytes;
      rebuild_heap();
    end
    @(negedge clk);
    live_blocks.delete();
    released_addrs.delete();
    tx_idle = tx;
    rx_idle = rx;
    if (hold) hold_req++;
    run_random(count);
  endtask

  initial begin
    cur_base = '0;
    cur_bytes = 15'd16384;
    rebuild_heap();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: rejects, rounding, split/no split, double and stray frees, full merge
    push_op(CMD_ALLOC, 15'd0, 32'hFFFF_FFFF);
    push_op(CMD_FREE, 15'h7FFF, 32'd0);
    push_op(CMD_ALLOC, 15'h7FFF, 32'd0);
    push_op(CMD_ALLOC, 15'd16373, 32'd0);
    push_op(CMD_ALLOC, 15'd1, 32'd0);
    push_op(CMD_ALLOC, 15'd4, 32'd0);
    push_op(CMD_ALLOC, 15'd17, 32'd0);
    push_op(CMD_FREE, 15'd0, 32'd28);
    push_op(CMD_FREE, 15'd0, 32'd28);
    push_op(CMD_FREE, 15'd0, 32'd30);
    push_op(CMD_ALLOC, 15'd4, 32'hFFFF_FFFF);
    push_op(CMD_FREE, 15'd0, 32'd28);
    push_op(CMD_FREE, 15'd0, 32'd12);
    push_op(CMD_FREE, 15'd0, 32'd44);
    push_op(CMD_ALLOC, 15'd16372, 32'd0);
    push_op(CMD_ALLOC, 15'd1, 32'd0);
    push_op(CMD_FREE, 15'h7FFF, 32'hFFFF_FFFF);
    push_op(CMD_FREE, 15'd0, 32'd12);
    push_op(CMD_ALLOC, 15'd16345, 32'd0);
    push_op(CMD_FREE, 15'd0, 32'd12);
    push_op(CMD_ALLOC, 15'd16344, 32'd0);
    push_op(CMD_ALLOC, 15'd13, 32'd0);
    push_op(CMD_FREE, 15'd0, 32'd16368);
    push_op(CMD_FREE, 15'd0, 32'd12);

    run_phase(32'hFFFF_FFF0, 15'd0, 1'b0, 1'b0, 1'b1, 1'b1, 60);
    run_phase(32'h0000_1000, 15'd0, 1'b1, 1'b1, 1'b1, 1'b0, 30);
    run_phase($urandom, 15'd203, 1'b1, 1'b0, 1'b1, 1'b0, 50);
    run_phase(32'hFFFF_FFFF, 15'h7FFF, 1'b1, 1'b1, 1'b1, 1'b0, 80);
    run_phase($urandom, 15'd1000, 1'b1, 1'b1, 1'b0, 1'b0, 60);
    run_phase(32'h0000_0000, 15'd16385, 1'b1, 1'b0, 1'b0, 1'b0, 80);
    run_phase(32'h8000_0000, 15'd16384, 1'b1, 1'b1, 1'b1, 1'b0, 70);

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && heap_replies.size() == 0) begin
      $display("PASS first_fit_heap_allocator");
    end else begin
      $display("FAIL first_fit_heap_allocator");
    end
    $finish;
  end

endmodule
